>>> rtl/ipv4fl_pkg.sv
package ipv4fl_pkg;

	// table geometry
	localparam int ROUTE_DEPTH = 64;
	localparam int ARP_DEPTH   = 64;
	localparam int IFACE_BITS  = 4;

	localparam int ROUTE_AW  = (ROUTE_DEPTH > 1) ? $clog2(ROUTE_DEPTH) : 1;
	localparam int ARP_AW    = (ARP_DEPTH > 1) ? $clog2(ARP_DEPTH) : 1;
	localparam int MAX_DEPTH = (ROUTE_DEPTH > ARP_DEPTH) ? ROUTE_DEPTH : ARP_DEPTH;
	localparam int SCAN_CW   = $clog2(MAX_DEPTH + 1);

	// fixed field widths
	localparam int IDX_W      = 6;
	localparam int CNT_W      = 7;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	typedef enum logic [1:0] {
		CMD_LOAD_ROUTE = 2'd0,
		CMD_LOAD_ARP   = 2'd1,
		CMD_LOOKUP     = 2'd2,
		CMD_NOP        = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_LOADED        = 3'd0,
		STAT_FORWARD       = 3'd1,
		STAT_BAD_CSUM      = 3'd2,
		STAT_TIME_EXCEEDED = 3'd3,
		STAT_UNREACHABLE   = 3'd4,
		STAT_NO_ARP        = 3'd5
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ROUTE_COUNT = 1'b0,
		CFG_ARP_COUNT   = 1'b1
	} cfg_reg_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SCAN   = 2'd1,
		ST_RESULT = 2'd2
	} state_t;

	typedef struct packed {
		logic [31:0]           prefix;
		logic [31:0]           mask;
		logic [31:0]           gateway;
		logic [IFACE_BITS-1:0] iface;
	} route_ent_t;

	typedef struct packed {
		logic [31:0] ip;
		logic [47:0] mac;
	} arp_ent_t;

	typedef struct packed {
		logic done;
		logic found;
		logic hit;
	} scan_sts_t;

	// entry count register limited to the table depth
	function automatic logic [SCAN_CW-1:0] clamp_count(input logic [CNT_W-1:0] cnt,
		input int depth);
		logic [SCAN_CW-1:0] res;
		if (int'(cnt) > depth) begin
			res = SCAN_CW'(depth);
		end else begin
			res = SCAN_CW'(cnt);
		end
		return res;
	endfunction

endpackage

>>> rtl/ipv4_forward_lookup.sv
// channel   signals                                      direction
// -------   -------------------------------------------  ---------
// request   in_valid, in_stall, cmd .. header_ok          in
// result    out_valid, out_stall, status .. ttl_out       out
// config    cfg_we, cfg_index, cfg_data                   in
//
// load, nop and early-drop requests go from accept straight to the result state
// a lookup passes through the scan state first, where both tables are read one entry per cycle
// through their single read port
// one request at a time: in_stall is high from accept until the result is
// handed to the output register, which holds it while out_stall is high
// reset clears control and the count registers; table contents are kept
module ipv4_forward_lookup
	import ipv4fl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	// request channel
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [1:0]            cmd,
	input  logic [IDX_W-1:0]      entry_index,
	input  logic [31:0]           route_prefix_in,
	input  logic [31:0]           route_mask_in,
	input  logic [31:0]           next_hop_in,
	input  logic [IFACE_BITS-1:0] iface_in,
	input  logic [31:0]           arp_ip_in,
	input  logic [47:0]           arp_mac_in,
	input  logic [31:0]           dest_ip,
	input  logic [7:0]            ttl_in,
	input  logic                  header_ok,
	// result channel
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [2:0]            status,
	output logic [IFACE_BITS-1:0] out_iface,
	output logic [31:0]           out_next_hop,
	output logic [47:0]           dest_mac,
	output logic [7:0]            ttl_out,
	// configuration port
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	state_t state_q;
	state_t state_d;

	logic [CNT_W-1:0] route_count_q;
	logic [CNT_W-1:0] arp_count_q;

	// request fields kept for the lookup
	logic [31:0] dest_q;
	logic [7:0]  ttl_q;

	// result staged until the output register is free
	status_t               res_status_q;
	logic [IFACE_BITS-1:0] res_iface_q;
	logic [31:0]           res_hop_q;
	logic [47:0]           res_mac_q;
	logic [7:0]            res_ttl_q;

	// output register
	logic                  out_valid_q;
	status_t               out_status_q;
	logic [IFACE_BITS-1:0] out_iface_q;
	logic [31:0]           out_hop_q;
	logic [47:0]           out_mac_q;
	logic [7:0]            out_ttl_q;

	logic   acc;
	cmd_t   cmd_c;
	logic   early;
	status_t early_status;
	logic   scan_start;
	logic   out_load;

	logic [IDX_W+ROUTE_AW-1:0] route_idx_ext;
	logic [IDX_W+ARP_AW-1:0]   arp_idx_ext;
	logic                      route_we;
	logic                      arp_we;
	route_ent_t                route_wdata;
	arp_ent_t                  arp_wdata;

	logic                  route_re;
	logic [ROUTE_AW-1:0]   route_raddr;
	route_ent_t            route_rdata;
	logic                  arp_re;
	logic [ARP_AW-1:0]     arp_raddr;
	arp_ent_t              arp_rdata;
	scan_sts_t             scan_sts;
	logic [31:0]           scan_hop;
	logic [IFACE_BITS-1:0] scan_iface;
	logic [47:0]           scan_mac;

	assign in_stall = state_q != ST_IDLE;
	assign acc      = in_valid && (state_q == ST_IDLE);
	assign cmd_c    = cmd_t'(cmd);

	// decisions that need no table walk
	always_comb begin
		early        = 1'b1;
		early_status = STAT_LOADED;
		unique case (cmd_c)
			CMD_LOAD_ROUTE, CMD_LOAD_ARP, CMD_NOP: begin
				early_status = STAT_LOADED;
			end
			CMD_LOOKUP: begin
				if (!header_ok) begin
					early_status = STAT_BAD_CSUM;
				end else if (ttl_in <= 8'd1) begin
					early_status = STAT_TIME_EXCEEDED;
				end else begin
					early = 1'b0;
				end
			end
			default: begin
				early_status = STAT_LOADED;
			end
		endcase
	end

	assign scan_start = acc && !early;

	// table writes happen at the accept edge; slots past the depth are dropped
	assign route_idx_ext = {{ROUTE_AW{1'b0}}, entry_index};
	assign arp_idx_ext   = {{ARP_AW{1'b0}}, entry_index};
	assign route_we      = acc && (cmd_c == CMD_LOAD_ROUTE)
		&& (int'(entry_index) < ROUTE_DEPTH);
	assign arp_we        = acc && (cmd_c == CMD_LOAD_ARP)
		&& (int'(entry_index) < ARP_DEPTH);

	assign route_wdata.prefix  = route_prefix_in;
	assign route_wdata.mask    = route_mask_in;
	assign route_wdata.gateway = next_hop_in;
	assign route_wdata.iface   = iface_in;
	assign arp_wdata.ip        = arp_ip_in;
	assign arp_wdata.mac       = arp_mac_in;

	ipv4fl_route_tbl u_route_tbl (
		.clk   (clk),
		.we    (route_we),
		.waddr (route_idx_ext[ROUTE_AW-1:0]),
		.wdata (route_wdata),
		.re    (route_re),
		.raddr (route_raddr),
		.rdata (route_rdata)
	);

	ipv4fl_arp_tbl u_arp_tbl (
		.clk   (clk),
		.we    (arp_we),
		.waddr (arp_idx_ext[ARP_AW-1:0]),
		.wdata (arp_wdata),
		.re    (arp_re),
		.raddr (arp_raddr),
		.rdata (arp_rdata)
	);

	ipv4fl_scan u_scan (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (scan_start),
		.dest        (dest_q),
		.route_n     (clamp_count(route_count_q, ROUTE_DEPTH)),
		.arp_n       (clamp_count(arp_count_q, ARP_DEPTH)),
		.route_re    (route_re),
		.route_raddr (route_raddr),
		.route_rdata (route_rdata),
		.arp_re      (arp_re),
		.arp_raddr   (arp_raddr),
		.arp_rdata   (arp_rdata),
		.sts         (scan_sts),
		.best_hop    (scan_hop),
		.best_iface  (scan_iface),
		.mac         (scan_mac)
	);

	// count registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			route_count_q <= '0;
			arp_count_q   <= '0;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				CFG_ROUTE_COUNT: route_count_q <= cfg_data;
				CFG_ARP_COUNT:   arp_count_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign out_load = (state_q == ST_RESULT) && (!out_valid_q || !out_stall);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (acc) begin
					state_d = early ? ST_RESULT : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_sts.done) begin
					state_d = ST_RESULT;
				end
			end
			ST_RESULT: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// request capture and result staging
	always_ff @(posedge clk) begin
		if (acc) begin
			dest_q       <= dest_ip;
			ttl_q        <= ttl_in;
			res_status_q <= early_status;
			res_iface_q  <= '0;
			res_hop_q    <= '0;
			res_mac_q    <= '0;
			res_ttl_q    <= '0;
		end else if ((state_q == ST_SCAN) && scan_sts.done) begin
			if (!scan_sts.found) begin
				res_status_q <= STAT_UNREACHABLE;
			end else begin
				res_status_q <= scan_sts.hit ? STAT_FORWARD : STAT_NO_ARP;
				res_iface_q  <= scan_iface;
				res_hop_q    <= scan_hop;
				res_mac_q    <= scan_sts.hit ? scan_mac : 48'd0;
				res_ttl_q    <= ttl_q - 8'd1;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_status_q <= res_status_q;
			out_iface_q  <= res_iface_q;
			out_hop_q    <= res_hop_q;
			out_mac_q    <= res_mac_q;
			out_ttl_q    <= res_ttl_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = out_status_q;
	assign out_iface    = out_iface_q;
	assign out_next_hop = out_hop_q;
	assign dest_mac     = out_mac_q;
	assign ttl_out      = out_ttl_q;

	// scan completion only seen while the sequencer waits for it
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_sts.done |-> state_q == ST_SCAN)
		else $error("scan done outside scan state");

	// an accepted request always leaves idle
	a_acc_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q != ST_IDLE)
		else $error("accepted request did not start");

	// a forwarded packet carries a ttl of at least one
	a_fwd_ttl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && (out_status_q == STAT_FORWARD) |-> out_ttl_q != 8'd0)
		else $error("forward with zero ttl");

	// loads, early drops and unreachable results report no route data
	a_drop_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && ((out_status_q == STAT_LOADED) || (out_status_q == STAT_BAD_CSUM)
		|| (out_status_q == STAT_TIME_EXCEEDED) || (out_status_q == STAT_UNREACHABLE))
		|-> (out_hop_q == 32'd0) && (out_mac_q == 48'd0) && (out_ttl_q == 8'd0))
		else $error("dropped request carries route data");

endmodule

>>> rtl/ipv4fl_route_tbl.sv
module ipv4fl_route_tbl
	import ipv4fl_pkg::*;
(
	input  logic                clk,
	input  logic                we,
	input  logic [ROUTE_AW-1:0] waddr,
	input  route_ent_t          wdata,
	input  logic                re,
	input  logic [ROUTE_AW-1:0] raddr,
	output route_ent_t          rdata
);

	route_ent_t mem_q [ROUTE_DEPTH];
	route_ent_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ipv4fl_arp_tbl.sv
module ipv4fl_arp_tbl
	import ipv4fl_pkg::*;
(
	input  logic              clk,
	input  logic              we,
	input  logic [ARP_AW-1:0] waddr,
	input  arp_ent_t          wdata,
	input  logic              re,
	input  logic [ARP_AW-1:0] raddr,
	output arp_ent_t          rdata
);

	arp_ent_t mem_q [ARP_DEPTH];
	arp_ent_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/ipv4fl_scan.sv
module ipv4fl_scan
	import ipv4fl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [31:0]           dest,
	input  logic [SCAN_CW-1:0]    route_n,
	input  logic [SCAN_CW-1:0]    arp_n,
	output logic                  route_re,
	output logic [ROUTE_AW-1:0]   route_raddr,
	input  route_ent_t            route_rdata,
	output logic                  arp_re,
	output logic [ARP_AW-1:0]     arp_raddr,
	input  arp_ent_t              arp_rdata,
	output scan_sts_t             sts,
	output logic [31:0]           best_hop,
	output logic [IFACE_BITS-1:0] best_iface,
	output logic [47:0]           mac
);

	logic [SCAN_CW-1:0]    cnt_q;
	logic                  busy_q;
	logic                  rpend_s1;
	logic                  apend_s1;
	logic                  found_q;
	logic                  hit_q;
	logic [31:0]           best_mask_q;
	logic [31:0]           best_hop_q;
	logic [IFACE_BITS-1:0] best_iface_q;
	logic [47:0]           mac_q;

	logic r_issue;
	logic a_issue;
	logic r_match;
	logic r_better;
	logic a_match;
	logic done;

	// both tables are walked side by side, one entry per cycle each
	assign r_issue = busy_q && (cnt_q < route_n);
	assign a_issue = busy_q && (cnt_q < arp_n);
	assign done    = busy_q && !r_issue && !a_issue && !rpend_s1 && !apend_s1;

	assign route_re    = r_issue;
	assign route_raddr = cnt_q[ROUTE_AW-1:0];
	assign arp_re      = a_issue;
	assign arp_raddr   = cnt_q[ARP_AW-1:0];

	// compare on the registered read data
	assign r_match  = (dest & route_rdata.mask) == route_rdata.prefix;
	assign r_better = !found_q || (route_rdata.mask >= best_mask_q);
	assign a_match  = arp_rdata.ip == dest;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q    <= '0;
			busy_q   <= 1'b0;
			rpend_s1 <= 1'b0;
			apend_s1 <= 1'b0;
			found_q  <= 1'b0;
			hit_q    <= 1'b0;
		end else if (start) begin
			cnt_q    <= '0;
			busy_q   <= 1'b1;
			rpend_s1 <= 1'b0;
			apend_s1 <= 1'b0;
			found_q  <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			rpend_s1 <= r_issue;
			apend_s1 <= a_issue;
			if (r_issue || a_issue) begin
				cnt_q <= cnt_q + SCAN_CW'(1);
			end
			if (done) begin
				busy_q <= 1'b0;
			end
			if (rpend_s1 && r_match) begin
				found_q <= 1'b1;
			end
			if (apend_s1 && a_match) begin
				hit_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rpend_s1 && r_match && r_better) begin
			best_mask_q  <= route_rdata.mask;
			best_hop_q   <= route_rdata.gateway;
			best_iface_q <= route_rdata.iface;
		end
		if (apend_s1 && a_match) begin
			mac_q <= arp_rdata.mac;
		end
	end

	assign sts.done   = done;
	assign sts.found  = found_q;
	assign sts.hit    = hit_q;
	assign best_hop   = best_hop_q;
	assign best_iface = best_iface_q;
	assign mac        = mac_q;

endmodule
